FILE: rtl/core/tcc_pkg.sv
// Shared types and constants for the text cell console.
// Grid geometry, character codes, controller/datapath command and status types.
// No dependencies.
package tcc_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELLS      = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int COL_W      = 7;
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int OUT_ROW_W  = 5;
	localparam int OP_W       = 2;
	localparam int CHAR_W     = 8;
	localparam int POS_W      = 8;
	localparam int NIB_W      = 4;
	localparam int CELL_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int TAB_W      = 2;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	localparam logic [NIB_W-1:0]  FG_RESET   = 4'h7;
	localparam logic [NIB_W-1:0]  BG_RESET   = 4'h0;
	localparam logic [CELL_W-1:0] RESET_CELL = {BG_RESET, FG_RESET, CH_SPACE};

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FG = 1'b0,
		CFG_BG = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_HOME,
		CUR_CR,
		CUR_LEFT,
		CUR_ADVANCE,
		CUR_NEWLINE,
		CUR_SET
	} cur_cmd_t;

	typedef enum logic [1:0] {
		SWP_INIT,
		SWP_CLEAR,
		SWP_SCROLL
	} sweep_kind_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_INIT_END,
		ST_IDLE,
		ST_DECODE,
		ST_PLAIN,
		ST_SCROLL,
		ST_SCROLL_END,
		ST_CLEAR,
		ST_CLEAR_END,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        in_ready;
		cur_cmd_t    cur;
		logic        cell_wr;
		logic        wr_left;
		logic        sweep_go;
		sweep_kind_t sweep_kind;
		logic        tab_step;
		logic        mark_scroll;
		logic        rd_cap;
		logic        out_load;
	} cmd_t;

	typedef struct packed {
		logic in_fire;
		op_t  op;
		logic is_lf;
		logic is_cr;
		logic is_tab;
		logic is_bs;
		logic col_zero;
		logic col_last;
		logic row_last;
		logic tab_more_now;
		logic tab_more_after;
		logic sweep_last;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/core/tcc_if.sv
// Request and response channels of the text cell console.
// Depends on tcc_pkg for field widths.
interface tcc_req_if;
	import tcc_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [CHAR_W-1:0] char_code;
	logic [POS_W-1:0]  col;
	logic [POS_W-1:0]  row;
	modport source (output valid, op, char_code, col, row, input ready);
	modport sink (input valid, op, char_code, col, row, output ready);
endinterface

interface tcc_rsp_if;
	import tcc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [COL_W-1:0]     cursor_col;
	logic [OUT_ROW_W-1:0] cursor_row;
	logic [CHAR_W-1:0]    cell_char;
	logic [CHAR_W-1:0]    cell_attr;
	logic                 scrolled;
	modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
		input ready);
	modport sink (input valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
		output ready);
endinterface

FILE: rtl/core/tcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/tcc_ctrl.sv
// Controller state machine of the text cell console.
// Depends on tcc_pkg (state, command and status types).
module tcc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  tcc_pkg::status_t sts,
	output tcc_pkg::cmd_t    cmd
);
	import tcc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_d = ST_INIT_END;
			end
			ST_INIT_END: state_d = ST_IDLE;
			ST_IDLE: begin
				if (sts.in_fire) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (sts.op)
					OP_PUT: begin
						if (sts.is_lf) begin
							state_d = sts.row_last ? ST_SCROLL : ST_DONE;
						end else if (sts.is_cr) begin
							state_d = ST_DONE;
						end else if (sts.is_tab) begin
							state_d = ST_PLAIN;
						end else if (sts.is_bs) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_PLAIN;
						end
					end
					OP_SET:   state_d = ST_DONE;
					OP_CLEAR: state_d = ST_CLEAR;
					OP_READ:  state_d = ST_READ;
					default:  state_d = ST_DONE;
				endcase
			end
			ST_PLAIN: begin
				if (sts.col_last && sts.row_last) begin
					state_d = ST_SCROLL;
				end else if (sts.tab_more_now) begin
					state_d = ST_PLAIN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCROLL: begin
				if (sts.sweep_last) state_d = ST_SCROLL_END;
			end
			ST_SCROLL_END: state_d = sts.tab_more_after ? ST_PLAIN : ST_DONE;
			ST_CLEAR: begin
				if (sts.sweep_last) state_d = ST_CLEAR_END;
			end
			ST_CLEAR_END: state_d = ST_DONE;
			ST_READ:      state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.cur        = CUR_HOLD;
		cmd.sweep_kind = SWP_INIT;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_go   = 1'b1;
				cmd.sweep_kind = SWP_INIT;
			end
			ST_IDLE: cmd.in_ready = 1'b1;
			ST_DECODE: begin
				if (sts.op == OP_PUT) begin
					if (sts.is_lf) begin
						cmd.cur = CUR_NEWLINE;
					end else if (sts.is_cr) begin
						cmd.cur = CUR_CR;
					end else if (sts.is_bs && !sts.col_zero) begin
						cmd.cur     = CUR_LEFT;
						cmd.cell_wr = 1'b1;
						cmd.wr_left = 1'b1;
					end
				end else if (sts.op == OP_SET) begin
					cmd.cur = CUR_SET;
				end
			end
			ST_PLAIN: begin
				cmd.cell_wr  = 1'b1;
				cmd.cur      = CUR_ADVANCE;
				cmd.tab_step = 1'b1;
			end
			ST_SCROLL: begin
				cmd.sweep_go   = 1'b1;
				cmd.sweep_kind = SWP_SCROLL;
			end
			ST_SCROLL_END: cmd.mark_scroll = 1'b1;
			ST_CLEAR: begin
				cmd.sweep_go   = 1'b1;
				cmd.sweep_kind = SWP_CLEAR;
			end
			ST_CLEAR_END: cmd.cur = CUR_HOME;
			ST_READ:      cmd.rd_cap = 1'b1;
			ST_DONE:      cmd.out_load = sts.out_free;
			default: ;
		endcase
	end
endmodule

FILE: rtl/core/tcc_dp.sv
// Datapath of the text cell console: cursor, config, cell store, sweep pipe, result reg.
// Depends on tcc_pkg, tcc_if (channels) and tcc_ram.
module tcc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	tcc_req_if.sink                       req,
	tcc_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  tcc_pkg::cmd_t                 cmd,
	output tcc_pkg::status_t              sts
);
	import tcc_pkg::*;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
	endfunction

	function automatic logic [OUT_ROW_W-1:0] row_out(input logic [ROW_W-1:0] r);
		logic [31:0] w;
		w = 32'(r);
		return w[OUT_ROW_W-1:0];
	endfunction

	logic                 in_fire;
	op_t                  op_q;
	logic [CHAR_W-1:0]    chr_q;
	logic [POS_W-1:0]     col_in_q, row_in_q;
	logic [NIB_W-1:0]     fg_q, bg_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [TAB_W-1:0]     tab_q;
	logic                 scr_q;
	logic [CELL_W-1:0]    rd_q;
	logic [ADDR_W-1:0]    sweep_q;
	logic                 sw_v_s1, sw_tail_s1;
	sweep_kind_t          sw_kind_s1;
	logic [ADDR_W-1:0]    sw_addr_s1;
	logic                 out_v_q;
	logic [COL_W-1:0]     o_col_q;
	logic [OUT_ROW_W-1:0] o_row_q;
	logic [CELL_W-1:0]    o_cell_q;
	logic                 o_scr_q;

	logic                 col_ok, row_ok, in_rng, tail;
	logic [CHAR_W-1:0]    attr, put_chr;
	logic [CELL_W-1:0]    blank, rdata, wdata;
	logic [ADDR_W-1:0]    cur_addr, left_addr, in_addr, sweep_rd, raddr, waddr;
	logic                 we;

	assign in_fire   = req.valid && req.ready;
	assign req.ready = cmd.in_ready;

	assign col_ok = 32'(col_in_q) < 32'(COLUMNS);
	assign row_ok = 32'(row_in_q) < 32'(ROWS);
	assign in_rng = col_ok && row_ok;
	assign tail   = sweep_q >= ADDR_W'(CELLS - COLUMNS);

	assign attr    = {bg_q, fg_q};
	assign blank   = {attr, CH_SPACE};
	assign put_chr = (chr_q == CH_TAB) ? CH_SPACE : chr_q;

	assign cur_addr  = cell_addr(row_q, col_q);
	assign left_addr = cur_addr - ADDR_W'(1);
	assign in_addr   = in_rng ? cell_addr(ROW_W'(row_in_q), COL_W'(col_in_q)) : '0;
	assign sweep_rd  = tail ? sweep_q : sweep_q + ADDR_W'(COLUMNS);
	assign raddr     = cmd.sweep_go ? sweep_rd : in_addr;

	// write port: the sweep pipe owns it while active, else cursor writes
	always_comb begin
		we    = 1'b0;
		waddr = cur_addr;
		wdata = {attr, put_chr};
		if (sw_v_s1) begin
			we    = 1'b1;
			waddr = sw_addr_s1;
			case (sw_kind_s1)
				SWP_INIT:   wdata = RESET_CELL;
				SWP_SCROLL: wdata = sw_tail_s1 ? blank : rdata;
				default:    wdata = blank;
			endcase
		end else if (cmd.cell_wr) begin
			we = 1'b1;
			if (cmd.wr_left) begin
				waddr = left_addr;
				wdata = blank;
			end
		end
	end

	tcc_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= op_t'(req.op);
			chr_q    <= req.char_code;
			col_in_q <= req.col;
			row_in_q <= req.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FG) fg_q <= cfg_data;
			if (cfg_index == CFG_BG) bg_q <= cfg_data;
		end
	end

	// cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			case (cmd.cur)
				CUR_HOME: begin
					col_q <= '0;
					row_q <= '0;
				end
				CUR_CR:   col_q <= '0;
				CUR_LEFT: col_q <= col_q - COL_W'(1);
				CUR_ADVANCE: begin
					if (sts.col_last) begin
						col_q <= '0;
						if (!sts.row_last) row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				CUR_NEWLINE: begin
					col_q <= '0;
					if (!sts.row_last) row_q <= row_q + ROW_W'(1);
				end
				CUR_SET: begin
					if (col_ok) col_q <= COL_W'(col_in_q);
					if (row_ok) row_q <= ROW_W'(row_in_q);
				end
				default: ;
			endcase
		end
	end

	// per-item flags and read result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= '0;
			scr_q <= 1'b0;
			rd_q  <= '0;
		end else if (in_fire) begin
			tab_q <= '0;
			scr_q <= 1'b0;
			rd_q  <= '0;
		end else begin
			if (cmd.tab_step) tab_q <= tab_q + TAB_W'(1);
			if (cmd.mark_scroll) scr_q <= 1'b1;
			if (cmd.rd_cap && in_rng) rd_q <= rdata;
		end
	end

	// sweep address and one-stage write pipe (read k+COLUMNS, write k)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			sw_v_s1 <= 1'b0;
		end else begin
			sw_v_s1 <= cmd.sweep_go;
			if (cmd.sweep_go) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		sw_addr_s1 <= sweep_q;
		sw_kind_s1 <= cmd.sweep_kind;
		sw_tail_s1 <= tail;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_col_q  <= col_q;
			o_row_q  <= row_out(row_q);
			o_cell_q <= rd_q;
			o_scr_q  <= scr_q;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.cursor_col = o_col_q;
	assign rsp.cursor_row = o_row_q;
	assign rsp.cell_char  = o_cell_q[CHAR_W-1:0];
	assign rsp.cell_attr  = o_cell_q[CELL_W-1:CHAR_W];
	assign rsp.scrolled   = o_scr_q;

	always_comb begin
		sts                = '0;
		sts.in_fire        = in_fire;
		sts.op             = op_q;
		sts.is_lf          = chr_q == CH_LF;
		sts.is_cr          = chr_q == CH_CR;
		sts.is_tab         = chr_q == CH_TAB;
		sts.is_bs          = chr_q == CH_BS;
		sts.col_zero       = col_q == '0;
		sts.col_last       = col_q == COL_W'(COLUMNS - 1);
		sts.row_last       = row_q == ROW_W'(ROWS - 1);
		sts.tab_more_now   = (chr_q == CH_TAB) && (tab_q != TAB_W'(3));
		sts.tab_more_after = (chr_q == CH_TAB) && (tab_q != '0);
		sts.sweep_last     = sweep_q == ADDR_W'(CELLS - 1);
		sts.out_free       = !out_v_q || rsp.ready;
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(COLUMNS))
		else $error("cursor column left the grid");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < 32'(ROWS))
		else $error("cursor row left the grid");
	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		sw_v_s1 |-> !cmd.cell_wr)
		else $error("cursor write collides with sweep write");
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !sw_v_s1 && !cmd.sweep_go)
		else $error("request taken while the store is being swept");
	a_out_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_v_q || rsp.ready)
		else $error("result register overwritten before transfer");
endmodule

FILE: rtl/core/text_cell_console.sv
// Text cell console: COLUMNS x ROWS grid of {attr, char} cells, one result per request.
// The state machine takes one request at a time and accepts the next once the previous result
// has gone into the result register; a scroll or clear also sweeps the whole store through its
// single write port. Reset: cursor home, colors 7/0; then an init pass writes every cell
// to space/0x07 while req.ready stays low (config writes are taken throughout).
module text_cell_console (
	input  logic                           clk,
	input  logic                           arst_n,
	tcc_req_if.sink                        req,
	tcc_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcc_pkg::*;

	// The controller sequences one request at a time: decode, per-cell writes (a tab is four
	// passes through the plain-character state), whole-store sweeps for scroll/clear/init,
	// then a hand-off into the result register. The result register lets the next request
	// transfer in while the previous result still waits on rsp.
	cmd_t    cmd;
	status_t sts;

	tcc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	// Datapath: cursor, color regs, cell store RAM, sweep pipe (scroll reads cell k+COLUMNS
	// and writes it to k on the following cycle; the bottom row gets blanks) and result register.
	tcc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);
endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for text_cell_console: runs console ops, checks every reply.
// Needs tcc_pkg and the tcc_req_if / tcc_rsp_if interfaces from the RTL tree.
module testbench;
	import tcc_pkg::*;

	// Worst case per op: a scroll or clear sweep plus the longest sender gap and
	// receiver stall, for every op of the run, plus the init sweep. Taken 3x.
	localparam int ITEM_BOUND  = 1800;
	localparam int CYCLE_LIMIT = 3 * (ITEM_BOUND * (CELLS + 64) + CELLS + 1000);
	localparam int PRINT_CAP   = 50;

	// One reply as the console reports it.
	typedef struct packed {
		logic [COL_W-1:0]     col;
		logic [OUT_ROW_W-1:0] row;
		logic [CHAR_W-1:0]    ch;
		logic [CHAR_W-1:0]    attr;
		logic                 scrolled;
	} reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tcc_req_if req();
	tcc_rsp_if rsp();

	text_cell_console DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the console: cell grid, cursor and current colors.
	logic [CELL_W-1:0] screen [CELLS];
	int                cur_col;
	int                cur_row;
	logic [NIB_W-1:0]  fg_now;
	logic [NIB_W-1:0]  bg_now;

	reply_t replies_due [$];   // predicted replies, oldest first
	reply_t want_reply;
	int     items_sent;
	int     reply_count;
	int     mismatches;
	int     cycle_count;

	// Flow control knobs shared by the sender and the reply throttle.
	bit idle_en;     // random bursts of idling allowed
	bit quiet;       // temporary calm stretch with no idling
	int hold_req;    // long receiver hold-off, in cycles, picked up by the throttle
	int hold_left;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow model of the console
	// ------------------------------------------------------------------

	function automatic logic [CELL_W-1:0] blank_cell();
		return {bg_now, fg_now, CH_SPACE};
	endfunction

	// Move every row up one, blank the bottom row with the current colors.
	function automatic void scroll_screen();
		logic [CELL_W-1:0] b;
		int                i;
		b = blank_cell();
		for (i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (i = CELLS - COLUMNS; i < CELLS; i++)
			screen[i] = b;
	endfunction

	// Newline: column home, next row; past the bottom the grid scrolls.
	function automatic bit next_line();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			scroll_screen();
			cur_row = ROWS - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Store one glyph at the cursor and advance, wrapping at the last column.
	function automatic bit type_glyph(logic [CHAR_W-1:0] ch);
		screen[cur_row * COLUMNS + cur_col] = {bg_now, fg_now, ch};
		cur_col++;
		if (cur_col >= COLUMNS)
			return next_line();
		return 1'b0;
	endfunction

	// Apply one console op to the shadow and return the reply it must produce.
	function automatic reply_t apply_console_op(op_t op, logic [CHAR_W-1:0] ch,
		logic [POS_W-1:0] c, logic [POS_W-1:0] r);
		reply_t            rep;
		logic [CELL_W-1:0] v;
		bit                moved_up;
		int                k;
		rep      = '0;
		moved_up = 1'b0;
		case (op)
			OP_PUT: begin
				case (ch)
					CH_LF: moved_up = next_line();
					CH_CR: cur_col = 0;
					CH_TAB: begin
						// four spaces, each may wrap; any scroll sets the flag
						for (k = 0; k < 4; k++)
							moved_up |= type_glyph(CH_SPACE);
					end
					CH_BS: begin
						// erase to the left, never back onto the row above
						if (cur_col > 0) begin
							cur_col--;
							screen[cur_row * COLUMNS + cur_col] = blank_cell();
						end
					end
					default: moved_up = type_glyph(ch);
				endcase
			end
			OP_SET: begin
				// each axis clamps on its own: out of range keeps the old value
				if (int'(c) < COLUMNS)
					cur_col = int'(c);
				if (int'(r) < ROWS)
					cur_row = int'(r);
			end
			OP_CLEAR: begin
				for (k = 0; k < CELLS; k++)
					screen[k] = blank_cell();
				cur_col = 0;
				cur_row = 0;
			end
			default: begin
				// out-of-range read returns zeros
				if (int'(c) < COLUMNS && int'(r) < ROWS) begin
					v        = screen[int'(r) * COLUMNS + int'(c)];
					rep.ch   = v[CHAR_W-1:0];
					rep.attr = v[CELL_W-1:CHAR_W];
				end
			end
		endcase
		rep.col      = COL_W'(cur_col);
		rep.row      = OUT_ROW_W'(cur_row);
		rep.scrolled = moved_up;
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// Reply checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string field, int got, int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("reply %0d: %s = %0d, predicted %0d", reply_count, field, got, want);
	endtask

	// Every reply transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			reply_count++;
			if (replies_due.size() == 0) begin
				report_mismatch("reply with nothing outstanding", 1, 0);
			end else begin
				want_reply = replies_due.pop_front();
				if (rsp.cursor_col !== want_reply.col)
					report_mismatch("cursor_col", int'(rsp.cursor_col),
						int'(want_reply.col));
				if (rsp.cursor_row !== want_reply.row)
					report_mismatch("cursor_row", int'(rsp.cursor_row),
						int'(want_reply.row));
				if (rsp.cell_char !== want_reply.ch)
					report_mismatch("cell_char", int'(rsp.cell_char), int'(want_reply.ch));
				if (rsp.cell_attr !== want_reply.attr)
					report_mismatch("cell_attr", int'(rsp.cell_attr), int'(want_reply.attr));
				if (rsp.scrolled !== want_reply.scrolled)
					report_mismatch("scrolled", int'(rsp.scrolled),
						int'(want_reply.scrolled));
			end
		end
	end

	// Reply-side throttle: a requested long hold-off first, then random stall
	// bursts, with calm stretches now and then.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (idle_en && $urandom_range(0, 299) == 0)
			quiet = !quiet;
		if (hold_left != 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else if (idle_en && !quiet && $urandom_range(0, 4) == 0) begin
			stall_left = int'($urandom_range(1, 12)) - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Watchdog: a hang or a lost reply ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
			replies_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offer one request, maybe after a gap; predict its reply on the transfer.
	// Returns in the step of the transfer edge, valid still high.
	task automatic send_cmd(op_t op, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] c,
		logic [POS_W-1:0] r);
		if (idle_en && !quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.op        <= op;
		req.char_code <= ch;
		req.col       <= c;
		req.row       <= r;
		do
			@(posedge clk);
		while (!req.ready);
		items_sent++;
		replies_due.push_back(apply_console_op(op, ch, c, r));
	endtask

	// Sender pause: drop valid and wait for every outstanding reply.
	task automatic drain_replies();
		req.valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// Color registers are only written with the console idle.
	task automatic set_colors(logic [NIB_W-1:0] fg, logic [NIB_W-1:0] bg);
		drain_replies();
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FG;
		cfg_data  <= fg;
		@(posedge clk);
		cfg_index <= CFG_BG;
		cfg_data  <= bg;
		@(posedge clk);
		cfg_we    <= 1'b0;
		fg_now = fg;
		bg_now = bg;
	endtask

	function automatic logic [CHAR_W-1:0] control_char();
		case ($urandom_range(0, 3))
			0: return CH_LF;
			1: return CH_CR;
			2: return CH_TAB;
			default: return CH_BS;
		endcase
	endfunction

	// A run of printable text, usually closed by a line break.
	task automatic send_text_line();
		int n;
		n = $urandom_range(3, 40);
		repeat (n)
			send_cmd(OP_PUT, CHAR_W'($urandom_range(32, 126)), POS_W'($urandom_range(0, 255)),
				POS_W'($urandom_range(0, 255)));
		case ($urandom_range(0, 2))
			0: begin
				send_cmd(OP_PUT, CH_CR, POS_W'($urandom_range(0, 255)),
					POS_W'($urandom_range(0, 255)));
				send_cmd(OP_PUT, CH_LF, POS_W'($urandom_range(0, 255)),
					POS_W'($urandom_range(0, 255)));
			end
			1: send_cmd(OP_PUT, CH_LF, POS_W'($urandom_range(0, 255)),
				POS_W'($urandom_range(0, 255)));
			default: ;
		endcase
	endtask

	// One random op; unused fields carry random bytes too.
	task automatic send_random_item();
		int               pick;
		int               tmp;
		logic [CHAR_W-1:0] ch;
		logic [POS_W-1:0]  c;
		logic [POS_W-1:0]  r;
		pick = $urandom_range(0, 99);
		ch   = CHAR_W'($urandom_range(0, 255));
		c    = POS_W'($urandom_range(0, 255));
		r    = POS_W'($urandom_range(0, 255));
		if (pick < 52) begin
			if ($urandom_range(0, 3) == 0)
				ch = control_char();
			send_cmd(OP_PUT, ch, c, r);
		end else if (pick < 63) begin
			// mostly in range; bottom rows favored so newlines reach the scroll
			if ($urandom_range(0, 3) != 0)
				c = POS_W'($urandom_range(0, COLUMNS - 1));
			if ($urandom_range(0, 3) != 0)
				r = POS_W'($urandom_range(0, 1) ? $urandom_range(ROWS - 5, ROWS - 1) :
					$urandom_range(0, ROWS - 1));
			send_cmd(OP_SET, ch, c, r);
		end else if (pick < 66) begin
			send_cmd(OP_CLEAR, ch, c, r);
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					// just behind the cursor, where text has landed
					tmp = cur_col - int'($urandom_range(0, 3));
					c   = POS_W'((tmp < 0) ? 0 : tmp);
					r   = POS_W'(cur_row);
				end
				1: begin
					c = POS_W'($urandom_range(0, COLUMNS - 1));
					r = POS_W'($urandom_range(0, ROWS - 1));
				end
				default: ;
			endcase
			send_cmd(OP_READ, ch, c, r);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// After the init sweep every cell is a space in light gray on black.
	task automatic test_reset_contents();
		send_cmd(OP_READ, 8'h00, 8'd0, 8'd0);
		send_cmd(OP_READ, 8'hFF, POS_W'(COLUMNS - 1), POS_W'(ROWS - 1));
		send_cmd(OP_READ, 8'h5A, POS_W'(COLUMNS / 2), POS_W'(ROWS / 2));
	endtask

	// Plain bytes at both extremes and the edit keys.
	task automatic test_edit_keys();
		send_cmd(OP_PUT, 8'h41, 8'hFF, 8'hFF);
		send_cmd(OP_PUT, 8'h00, 8'h00, 8'h00);
		send_cmd(OP_PUT, 8'hFF, 8'h00, 8'h00);
		send_cmd(OP_PUT, CH_BS, 8'h00, 8'h00);      // erases the 0xFF cell
		send_cmd(OP_READ, 8'hFF, 8'd2, 8'd0);
		send_cmd(OP_READ, 8'h00, 8'd1, 8'd0);
		send_cmd(OP_PUT, CH_CR, 8'h00, 8'h00);      // column home, row kept
		send_cmd(OP_PUT, CH_BS, 8'h00, 8'h00);      // at column zero: no effect
		send_cmd(OP_PUT, CH_TAB, 8'h00, 8'h00);
	endtask

	// Cursor clamping, wrap and scroll at the bottom edge, reads off the grid, clear.
	task automatic test_cursor_limits();
		send_cmd(OP_SET, 8'h00, 8'd200, 8'd3);       // column out of range
		send_cmd(OP_SET, 8'h00, 8'd10, 8'd200);      // row out of range
		send_cmd(OP_SET, 8'h00, 8'hFF, 8'hFF);       // both out: no move
		send_cmd(OP_SET, 8'h00, POS_W'(COLUMNS - 1), POS_W'(ROWS - 1));
		send_cmd(OP_PUT, 8'h5A, 8'h00, 8'h00);       // last cell: wrap and scroll
		send_cmd(OP_READ, 8'h00, POS_W'(COLUMNS - 1), POS_W'(ROWS - 2));
		send_cmd(OP_SET, 8'h00, POS_W'(COLUMNS - 2), POS_W'(ROWS - 1));
		send_cmd(OP_PUT, CH_TAB, 8'h00, 8'h00);      // tab wraps mid-way
		send_cmd(OP_SET, 8'h00, 8'd5, POS_W'(ROWS - 1));
		send_cmd(OP_PUT, CH_LF, 8'h00, 8'h00);       // newline off the bottom
		send_cmd(OP_READ, 8'h00, POS_W'(COLUMNS), 8'd0);
		send_cmd(OP_READ, 8'h00, 8'd0, POS_W'(ROWS));
		send_cmd(OP_READ, 8'h00, 8'hFF, 8'hFF);
		send_cmd(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(OP_READ, 8'h00, 8'd0, 8'd0);
	endtask

	// Mixed traffic: mostly single ops, sometimes whole lines of text.
	task automatic test_random_traffic(int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0)
				send_text_line();
			else
				send_random_item();
		end
	endtask

	// Receiver holds off long enough for the console to back up and stall its
	// request side; then the sender waits for every reply before going on.
	task automatic test_output_backpressure();
		hold_req = 300;
		repeat (30)
			send_random_item();
		drain_replies();
		repeat (10)
			send_random_item();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		int k;
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.op        = OP_PUT;
		req.char_code = '0;
		req.col       = '0;
		req.row       = '0;
		rsp.ready     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_FG;
		cfg_data      = '0;
		idle_en       = 1'b1;
		quiet         = 1'b0;
		hold_req      = 0;
		hold_left     = 0;
		stall_left    = 0;
		items_sent    = 0;
		reply_count   = 0;
		mismatches    = 0;
		fg_now        = FG_RESET;
		bg_now        = BG_RESET;
		cur_col       = 0;
		cur_row       = 0;
		for (k = 0; k < CELLS; k++)
			screen[k] = {BG_RESET, FG_RESET, CH_SPACE};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset colors still in force for the directed part
		test_reset_contents();
		test_edit_keys();
		test_cursor_limits();

		set_colors(4'hF, 4'hF);
		test_random_traffic(350);

		set_colors(4'h0, 4'h0);
		test_output_backpressure();

		set_colors(NIB_W'($urandom_range(0, 15)), NIB_W'($urandom_range(0, 15)));
		test_random_traffic(350);

		set_colors(4'h5, 4'hA);
		test_random_traffic(350);

		// last stretch at full rate on both sides
		idle_en = 1'b0;
		set_colors(NIB_W'($urandom_range(0, 15)), NIB_W'($urandom_range(0, 15)));
		test_random_traffic(350);

		drain_replies();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
